/* rtl/ile_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list engine package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ile_pkg;

    localparam int CAPACITY   = 32;
    localparam int AW         = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int POS_W      = 6;
    localparam int ELEM_CNT_W = 6;
    localparam int ST_W       = 2;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_INSERT   = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_SIZE     = 3'd4,
        OP_REPORT   = 3'd5
    } t_opcode;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP_WR,
        S_INS_SHIFT,
        S_INS_WR,
        S_REM_SHIFT,
        S_SCAN,
        S_REP_RD,
        S_REP_LD,
        S_RESP
    } t_state;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_LEN,
        IDX_POS,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC
    } t_idx_op;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_MOVE_DN,
        RD_MOVE_UP,
        RD_CMP,
        RD_PLAIN
    } t_rd_op;

    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_RESP,
        OUT_ELEM
    } t_out_op;

    typedef struct packed {
        logic    cap;
        t_idx_op idx_op;
        t_rd_op  rd_op;
        logic    wr_val;
        logic    len_inc;
        logic    len_dec;
        t_out_op out_op;
        t_status st;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic ins_ok;
        logic rem_ok;
        logic ins_more;
        logic rem_more;
        logic scan_more;
        logic elem_last;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ile_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed list engine controller
// Decodes each request and sequences the datapath through its steps.
// ----------------------------------------------------------------------------
module ile_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [ile_pkg::OP_W-1:0] i_opcode,
    input  ile_pkg::t_stat         i_stat,
    output logic                   o_in_ready,
    output ile_pkg::t_cmd          o_cmd
);

    import ile_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_status r_st;
    t_status n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_st         = r_st;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.idx_op = IDX_HOLD;
        o_cmd.rd_op  = RD_NONE;
        o_cmd.out_op = OUT_NONE;
        o_cmd.st     = r_st;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    n_st      = ST_OK;
                    n_state   = S_RESP;
                    case (t_opcode'(i_opcode))
                        OP_APPEND: begin
                            if (i_stat.full) begin
                                n_st = ST_FULL;
                            end else begin
                                o_cmd.idx_op = IDX_LEN;
                                n_state      = S_APP_WR;
                            end
                        end
                        OP_INSERT: begin
                            if (i_stat.full) begin
                                n_st = ST_FULL;
                            end else if (!i_stat.ins_ok) begin
                                n_st = ST_RANGE;
                            end else begin
                                o_cmd.idx_op = IDX_LEN;
                                n_state      = S_INS_SHIFT;
                            end
                        end
                        OP_REMOVE: begin
                            if (i_stat.empty) begin
                                n_st = ST_EMPTY;
                            end else if (!i_stat.rem_ok) begin
                                n_st = ST_RANGE;
                            end else begin
                                o_cmd.idx_op = IDX_POS;
                                n_state      = S_REM_SHIFT;
                            end
                        end
                        OP_CONTAINS: begin
                            o_cmd.idx_op = IDX_ZERO;
                            n_state      = S_SCAN;
                        end
                        OP_REPORT: begin
                            if (i_stat.empty) begin
                                n_st = ST_EMPTY;
                            end else begin
                                o_cmd.idx_op = IDX_ZERO;
                                n_state      = S_REP_RD;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_APP_WR: begin
                o_cmd.wr_val  = 1'b1;
                o_cmd.len_inc = 1'b1;
                n_state       = S_RESP;
            end
            S_INS_SHIFT: begin
                if (i_stat.ins_more) begin
                    o_cmd.rd_op  = RD_MOVE_DN;
                    o_cmd.idx_op = IDX_DEC;
                end else begin
                    n_state = S_INS_WR;
                end
            end
            S_INS_WR: begin
                o_cmd.wr_val  = 1'b1;
                o_cmd.len_inc = 1'b1;
                n_state       = S_RESP;
            end
            S_REM_SHIFT: begin
                if (i_stat.rem_more) begin
                    o_cmd.rd_op  = RD_MOVE_UP;
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    o_cmd.len_dec = 1'b1;
                    n_state       = S_RESP;
                end
            end
            S_SCAN: begin
                if (i_stat.scan_more) begin
                    o_cmd.rd_op  = RD_CMP;
                    o_cmd.idx_op = IDX_INC;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_REP_RD: begin
                o_cmd.rd_op = RD_PLAIN;
                n_state     = S_REP_LD;
            end
            S_REP_LD: begin
                if (i_stat.out_free) begin
                    o_cmd.out_op = OUT_ELEM;
                    o_cmd.idx_op = IDX_INC;
                    n_state      = i_stat.elem_last ? S_IDLE : S_REP_RD;
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_op = OUT_RESP;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/ile_dp.sv */
// ----------------------------------------------------------------------------
// Indexed list engine datapath
// Element store, length and index counters, search flag and result register.
// ----------------------------------------------------------------------------
module ile_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ile_pkg::t_cmd                      i_cmd,
    output ile_pkg::t_stat                     o_stat,
    input  logic [ile_pkg::POS_W-1:0]          i_position,
    input  logic signed [ile_pkg::DATA_W-1:0]  i_item_value,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [ile_pkg::DATA_W-1:0]  o_out_value,
    output logic                               o_found,
    output logic [ile_pkg::ELEM_CNT_W-1:0]     o_element_count,
    output logic [ile_pkg::ST_W-1:0]           o_status,
    output logic                               o_last
);

    import ile_pkg::*;

    logic [CNT_W-1:0]      r_len;
    logic [CNT_W-1:0]      n_len;
    logic [CNT_W-1:0]      r_idx;
    logic [CNT_W-1:0]      n_idx;
    logic [CNT_W-1:0]      r_pos;
    logic [DATA_W-1:0]     r_val;
    logic                  r_found;
    logic                  n_found;
    logic                  r_mv_pend;
    logic [AW-1:0]         r_mv_dst;
    logic                  r_cmp_pend;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [DATA_W-1:0]     r_out_value;
    logic                  r_out_found;
    logic [ELEM_CNT_W-1:0] r_out_cnt;
    logic [ST_W-1:0]       r_out_st;
    logic                  r_out_last;

    logic [CNT_W-1:0]      w_pos_in;
    logic [CNT_W-1:0]      w_idx_m1;
    logic [CNT_W-1:0]      w_idx_p1;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_W-1:0]     w_rd_data;
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_W-1:0]     w_wr_data;

    assign w_pos_in = CNT_W'(i_position);
    assign w_idx_m1 = r_idx - CNT_W'(1);
    assign w_idx_p1 = r_idx + CNT_W'(1);

    always_comb begin
        o_stat.full      = (r_len == CNT_W'(CAPACITY));
        o_stat.empty     = (r_len == '0);
        o_stat.ins_ok    = (w_pos_in <= r_len);
        o_stat.rem_ok    = (w_pos_in < r_len);
        o_stat.ins_more  = (r_idx > r_pos);
        o_stat.rem_more  = (w_idx_p1 < r_len);
        o_stat.scan_more = (r_idx < r_len);
        o_stat.elem_last = (w_idx_p1 == r_len);
        o_stat.out_free  = !r_out_valid || i_out_ready;
    end

    always_comb begin
        w_rd_en = (i_cmd.rd_op != RD_NONE);
        case (i_cmd.rd_op)
            RD_MOVE_DN: w_rd_addr = w_idx_m1[AW-1:0];
            RD_MOVE_UP: w_rd_addr = w_idx_p1[AW-1:0];
            default:    w_rd_addr = r_idx[AW-1:0];
        endcase
        w_wr_en = r_mv_pend || i_cmd.wr_val;
        if (r_mv_pend) begin
            w_wr_addr = r_mv_dst;
            w_wr_data = w_rd_data;
        end else begin
            w_wr_addr = r_idx[AW-1:0];
            w_wr_data = r_val;
        end
    end

    ile_ram #(
        .WIDTH(DATA_W),
        .DEPTH(CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    always_comb begin
        n_len = r_len;
        if (i_cmd.len_inc) begin
            n_len = r_len + CNT_W'(1);
        end else if (i_cmd.len_dec) begin
            n_len = r_len - CNT_W'(1);
        end
        case (i_cmd.idx_op)
            IDX_LEN:  n_idx = r_len;
            IDX_POS:  n_idx = w_pos_in;
            IDX_ZERO: n_idx = '0;
            IDX_INC:  n_idx = w_idx_p1;
            IDX_DEC:  n_idx = w_idx_m1;
            default:  n_idx = r_idx;
        endcase
        n_found = r_found;
        if (i_cmd.cap) begin
            n_found = 1'b0;
        end else if (r_cmp_pend && (w_rd_data == r_val)) begin
            n_found = 1'b1;
        end
        n_out_valid = r_out_valid && !i_out_ready;
        if (i_cmd.out_op != OUT_NONE) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_mv_pend   <= 1'b0;
            r_cmp_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_len       <= n_len;
            r_mv_pend   <= (i_cmd.rd_op == RD_MOVE_DN) || (i_cmd.rd_op == RD_MOVE_UP);
            r_cmp_pend  <= (i_cmd.rd_op == RD_CMP);
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx    <= n_idx;
        r_found  <= n_found;
        r_mv_dst <= r_idx[AW-1:0];
        if (i_cmd.cap) begin
            r_pos <= w_pos_in;
            r_val <= i_item_value;
        end
        case (i_cmd.out_op)
            OUT_RESP: begin
                r_out_value <= '0;
                r_out_found <= r_found;
                r_out_cnt   <= ELEM_CNT_W'(r_len);
                r_out_st    <= i_cmd.st;
                r_out_last  <= 1'b1;
            end
            OUT_ELEM: begin
                r_out_value <= w_rd_data;
                r_out_found <= 1'b0;
                r_out_cnt   <= ELEM_CNT_W'(r_len);
                r_out_st    <= ST_OK;
                r_out_last  <= o_stat.elem_last;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid     = r_out_valid;
    assign o_out_value     = r_out_value;
    assign o_found         = r_out_found;
    assign o_element_count = r_out_cnt;
    assign o_status        = r_out_st;
    assign o_last          = r_out_last;

endmodule

/* rtl/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of signed 32-bit values with insert, remove, search and report.
// ----------------------------------------------------------------------------
// One request is in work at a time; the single read and write port of the element store
// paces the shifts, the search and the report. A result may wait in the output register
// while the next request is taken. Reset empties the list; store contents are not cleared.
// ----------------------------------------------------------------------------
module indexed_list_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [ile_pkg::OP_W-1:0]           i_opcode,
    input  logic [ile_pkg::POS_W-1:0]          i_position,
    input  logic signed [ile_pkg::DATA_W-1:0]  i_item_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [ile_pkg::DATA_W-1:0]  o_out_value,
    output logic                               o_found,
    output logic [ile_pkg::ELEM_CNT_W-1:0]     o_element_count,
    output logic [ile_pkg::ST_W-1:0]           o_status,
    output logic                               o_last
);

    import ile_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    ile_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    ile_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .i_out_ready     (i_out_ready),
        .o_out_valid     (o_out_valid),
        .o_out_value     (o_out_value),
        .o_found         (o_found),
        .o_element_count (o_element_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

/* verif/indexed_list_engine_tb.sv */
// ----------------------------------------------------------------------------
// Indexed list engine testbench
// Drives list requests through the valid/ready input and checks every result
// against a shadow copy of the list kept in the bench, or against a result
// written by hand for a typed row. A short table of directed requests covers
// the empty list, the extremes of position and value and the empty and
// out-of-range statuses. Random requests then grow, shrink and mix the list,
// with random gaps both sides outside the last phase; one long output stall.
// ----------------------------------------------------------------------------
module indexed_list_engine_tb;

    import ile_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;
    localparam int RANDOM_ITEMS  = 195;
    localparam int STALL_CYCLES  = 160;
    localparam int DRAIN_CYCLES  = 48;
    localparam int DIRECTED_ROWS = 25;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         pos;
        logic signed [DATA_W-1:0] val;
    } t_list_req;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     found;
        logic [ELEM_CNT_W-1:0]    count;
        t_status                  status;
        logic                     last;
    } t_list_rsp;

    typedef struct packed {
        t_list_req rq;
        logic      typed;
        t_list_rsp want;
    } t_directed_row;

    typedef enum int {
        MIX_OPS,
        GROW_LIST,
        SHRINK_LIST
    } t_traffic;

    localparam t_list_rsp PREDICTED = '{'0, 1'b0, '0, ST_OK, 1'b0};

    // Rows with typed set carry the single result written out by hand.
    localparam t_directed_row DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{'{OP_SIZE,     6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd0, ST_OK,    1'b1}},
        '{'{OP_REPORT,   6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd0, ST_EMPTY, 1'b1}},
        '{'{OP_REMOVE,   6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd0, ST_EMPTY, 1'b1}},
        '{'{OP_CONTAINS, 6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd0, ST_OK,    1'b1}},
        '{'{OP_INSERT,   6'd1,  32'sd9},           1'b1, '{0, 1'b0, 6'd0, ST_RANGE, 1'b1}},
        '{'{OP_INSERT,   6'd0,  32'sh8000_0000},   1'b1, '{0, 1'b0, 6'd1, ST_OK,    1'b1}},
        '{'{OP_APPEND,   6'd0,  32'sh7FFF_FFFF},   1'b1, '{0, 1'b0, 6'd2, ST_OK,    1'b1}},
        '{'{OP_INSERT,   6'd2,  -32'sd1},          1'b1, '{0, 1'b0, 6'd3, ST_OK,    1'b1}},
        '{'{OP_INSERT,   6'd1,  32'sd0},           1'b1, '{0, 1'b0, 6'd4, ST_OK,    1'b1}},
        '{'{OP_CONTAINS, 6'd0,  32'sh8000_0000},   1'b1, '{0, 1'b1, 6'd4, ST_OK,    1'b1}},
        '{'{OP_CONTAINS, 6'd0,  32'sd5},           1'b1, '{0, 1'b0, 6'd4, ST_OK,    1'b1}},
        '{'{OP_REPORT,   6'd0,  32'sd0},           1'b0, PREDICTED},
        '{'{OP_REMOVE,   6'd4,  32'sd0},           1'b1, '{0, 1'b0, 6'd4, ST_RANGE, 1'b1}},
        '{'{OP_REMOVE,   6'd63, 32'sd0},           1'b1, '{0, 1'b0, 6'd4, ST_RANGE, 1'b1}},
        '{'{OP_INSERT,   6'd63, 32'sd1},           1'b1, '{0, 1'b0, 6'd4, ST_RANGE, 1'b1}},
        '{'{OP_INSERT,   6'd5,  32'sd1},           1'b1, '{0, 1'b0, 6'd4, ST_RANGE, 1'b1}},
        '{'{OP_REMOVE,   6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd3, ST_OK,    1'b1}},
        '{'{OP_REMOVE,   6'd2,  32'sd0},           1'b1, '{0, 1'b0, 6'd2, ST_OK,    1'b1}},
        '{'{OP_SPARE_6,  6'd63, -32'sd1},          1'b1, '{0, 1'b0, 6'd2, ST_OK,    1'b1}},
        '{'{OP_SPARE_7,  6'd0,  32'sd0},           1'b1, '{0, 1'b0, 6'd2, ST_OK,    1'b1}},
        '{'{OP_CONTAINS, 6'd0,  -32'sd1},          1'b1, '{0, 1'b0, 6'd2, ST_OK,    1'b1}},
        '{'{OP_REPORT,   6'd0,  32'sd0},           1'b0, PREDICTED},
        '{'{OP_APPEND,   6'd0,  32'sh5555_5555},   1'b0, PREDICTED},
        '{'{OP_INSERT,   6'd0,  32'shAAAA_AAAA},   1'b0, PREDICTED},
        '{'{OP_REPORT,   6'd0,  32'sd0},           1'b0, PREDICTED}
    };

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic [OP_W-1:0]           i_opcode;
    logic [POS_W-1:0]          i_position;
    logic signed [DATA_W-1:0]  i_item_value;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic signed [DATA_W-1:0]  o_out_value;
    logic                      o_found;
    logic [ELEM_CNT_W-1:0]     o_element_count;
    logic [ST_W-1:0]           o_status;
    logic                      o_last;

    logic signed [DATA_W-1:0]  list_image [CAPACITY];
    int                        list_image_len;
    t_list_rsp                 fresh_results [$];
    t_list_rsp                 pending_results [$];

    int  mismatch_count;
    int  requests_sent;
    int  results_checked;
    int  peak_length;
    int  status_seen [4];
    bit  tx_gaps_on;
    bit  rx_gaps_on;
    bit  long_stall_due;

    indexed_list_engine DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_opcode        (i_opcode),
        .i_position      (i_position),
        .i_item_value    (i_item_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_out_value     (o_out_value),
        .o_found         (o_found),
        .o_element_count (o_element_count),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Updates the shadow list and leaves the results of one request in fresh_results.
    function automatic void apply_list_op(input t_list_req rq);
        t_status st;
        logic    hit;
        int      i;
        st  = ST_OK;
        hit = 1'b0;
        fresh_results.delete();
        case (rq.op)
            OP_APPEND: begin
                if (list_image_len >= CAPACITY) begin
                    st = ST_FULL;
                end else begin
                    list_image[list_image_len] = rq.val;
                    list_image_len++;
                end
            end
            OP_INSERT: begin
                if (list_image_len >= CAPACITY) begin
                    st = ST_FULL;
                end else if (int'(rq.pos) > list_image_len) begin
                    st = ST_RANGE;
                end else begin
                    for (i = list_image_len; i > int'(rq.pos); i--) begin
                        list_image[i] = list_image[i - 1];
                    end
                    list_image[rq.pos] = rq.val;
                    list_image_len++;
                end
            end
            OP_REMOVE: begin
                if (list_image_len == 0) begin
                    st = ST_EMPTY;
                end else if (int'(rq.pos) >= list_image_len) begin
                    st = ST_RANGE;
                end else begin
                    for (i = int'(rq.pos); i + 1 < list_image_len; i++) begin
                        list_image[i] = list_image[i + 1];
                    end
                    list_image_len--;
                end
            end
            OP_CONTAINS: begin
                for (i = 0; i < list_image_len; i++) begin
                    if (list_image[i] == rq.val) begin
                        hit = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if (list_image_len > peak_length) begin
            peak_length = list_image_len;
        end
        if (rq.op == OP_REPORT && list_image_len == 0) begin
            fresh_results.push_back('{'0, 1'b0, '0, ST_EMPTY, 1'b1});
            st = ST_EMPTY;
        end else if (rq.op == OP_REPORT) begin
            for (i = 0; i < list_image_len; i++) begin
                fresh_results.push_back('{list_image[i], 1'b0, list_image_len[ELEM_CNT_W-1:0],
                                         ST_OK, (i + 1 == list_image_len)});
            end
        end else begin
            fresh_results.push_back('{'0, hit, list_image_len[ELEM_CNT_W-1:0], st, 1'b1});
        end
        status_seen[st]++;
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(0, 3) == 0) begin
            return int'($urandom_range(0, 8)) - 4;
        end
        return $urandom;
    endfunction

    function automatic t_list_req pick_request(input t_traffic mode);
        t_list_req rq;
        int        roll;
        bit        wild;
        roll    = $urandom_range(0, 99);
        wild    = 1'b0;
        rq.val  = pick_value();
        rq.pos  = POS_W'($urandom_range(0, 63));
        case (mode)
            GROW_LIST: begin
                if (roll < 50)      rq.op = OP_APPEND;
                else if (roll < 80) rq.op = OP_INSERT;
                else if (roll < 85) begin rq.op = OP_INSERT; wild = 1'b1; end
                else if (roll < 92) rq.op = OP_REPORT;
                else if (roll < 96) rq.op = OP_CONTAINS;
                else                rq.op = OP_REMOVE;
            end
            SHRINK_LIST: begin
                if (roll < 65)      rq.op = OP_REMOVE;
                else if (roll < 70) begin rq.op = OP_REMOVE; wild = 1'b1; end
                else if (roll < 80) rq.op = OP_REPORT;
                else if (roll < 90) rq.op = OP_CONTAINS;
                else                rq.op = OP_SIZE;
            end
            default: begin
                if (roll < 20)      rq.op = OP_APPEND;
                else if (roll < 38) rq.op = OP_INSERT;
                else if (roll < 58) rq.op = OP_REMOVE;
                else if (roll < 64) begin
                    rq.op = (roll[0]) ? OP_INSERT : OP_REMOVE;
                    wild  = 1'b1;
                end
                else if (roll < 76) rq.op = OP_CONTAINS;
                else if (roll < 84) rq.op = OP_SIZE;
                else if (roll < 94) rq.op = OP_REPORT;
                else                rq.op = (roll[0]) ? OP_SPARE_7 : OP_SPARE_6;
            end
        endcase
        if (!wild && rq.op == OP_INSERT) begin
            rq.pos = POS_W'($urandom_range(0, list_image_len));
        end
        if (!wild && rq.op == OP_REMOVE && list_image_len > 0) begin
            rq.pos = POS_W'($urandom_range(0, list_image_len - 1));
        end
        if (rq.op == OP_CONTAINS && list_image_len > 0 && $urandom_range(0, 1) == 1) begin
            rq.val = list_image[$urandom_range(0, list_image_len - 1)];
        end
        return rq;
    endfunction

    task automatic send_request(input t_list_req rq, input logic typed, input t_list_rsp want);
        while (tx_gaps_on && $urandom_range(0, 99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= rq.op;
        i_position   <= rq.pos;
        i_item_value <= rq.val;
        do @(posedge i_clk); while (!o_in_ready);
        apply_list_op(rq);
        if (typed) begin
            pending_results.push_back(want);
        end else begin
            foreach (fresh_results[n]) pending_results.push_back(fresh_results[n]);
        end
        requests_sent++;
    endtask

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_stall_due) begin
                long_stall_due = 1'b0;
                for (int n = 0; n < STALL_CYCLES; n++) begin
                    i_out_ready <= 1'b0;
                    @(posedge i_clk);
                end
            end
            i_out_ready <= !(rx_gaps_on && $urandom_range(0, 99) < 31);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_list_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: value %0d count %0d status %0d",
                                        o_out_value, o_element_count, o_status));
            end else begin
                want = pending_results.pop_front();
                if (o_out_value !== want.value || o_found !== want.found ||
                    o_element_count !== want.count || o_status !== want.status ||
                    o_last !== want.last) begin
                    flag_mismatch($sformatf({"result %0d: got value %0d found %0b count %0d ",
                                             "status %0d last %0b, want %0d %0b %0d %0d %0b"},
                                            results_checked, o_out_value, o_found,
                                            o_element_count, o_status, o_last, want.value,
                                            want.found, want.count, want.status, want.last));
                end
            end
        end
    end

    initial begin
        t_traffic mode;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_opcode       <= OP_SIZE;
        i_position     <= '0;
        i_item_value   <= '0;
        list_image_len = 0;
        tx_gaps_on     = 1'b1;
        rx_gaps_on     = 1'b1;
        long_stall_due = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_request(DIRECTED_PLAN[r].rq, DIRECTED_PLAN[r].typed, DIRECTED_PLAN[r].want);
        end

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k < 50)       mode = MIX_OPS;
            else if (k < 110) mode = GROW_LIST;
            else if (k < 170) mode = SHRINK_LIST;
            else              mode = MIX_OPS;
            tx_gaps_on = !(k >= 170 && k < 200);
            rx_gaps_on = tx_gaps_on;
            if (k == 95) begin
                long_stall_due = 1'b1;
            end
            send_request(pick_request(mode), 1'b0, PREDICTED);
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d requests and %0d results; longest list held %0d entries.",
                 requests_sent, results_checked, peak_length);
        $display("Error statuses raised: full %0d, out of range %0d, empty %0d.",
                 status_seen[ST_FULL], status_seen[ST_RANGE], status_seen[ST_EMPTY]);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
